### rtl/local_cfl_time_step_assert.svh
// Assertion macros shared by the local CFL time step RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef LOCAL_CFL_TIME_STEP_ASSERT_SVH
`define LOCAL_CFL_TIME_STEP_ASSERT_SVH
// Same-cycle implication.
`define LCTS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcts: same-cycle check failed");
// Next-cycle implication.
`define LCTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcts: next-cycle check failed");
`endif

### rtl/lcts_pkg.sv
// Constants and types for the local CFL time step block.
// No dependencies.
package lcts_pkg;
	localparam int FRAC = 16;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [17:0] ONE18 = 18'(1 << FRAC);
	localparam logic [17:0] GAMMA_RST = 18'd91750;
	localparam logic [25:0] CFL_RST = 26'd65536;

	localparam logic CFG_GAMMA = 1'b0;
	localparam logic CFG_CFL = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NEG_TEMP = 2'd1;
	localparam logic [1:0] ST_ZERO_RADII = 2'd2;

	typedef struct packed {
		logic [31:0] radius_xi;
		logic [31:0] radius_eta;
		logic [31:0] time_step;
		logic [1:0] status;
	} res_t;
endpackage

### rtl/lcts_in_if.sv
// Input item channel of the local CFL time step block.
// No dependencies.
interface lcts_in_if;
	logic valid;
	logic ready;
	logic [31:0] density;
	logic signed [31:0] momentum_x;
	logic signed [31:0] momentum_y;
	logic [31:0] total_energy;
	logic signed [31:0] metric_xi_x;
	logic signed [31:0] metric_xi_y;
	logic signed [31:0] metric_eta_x;
	logic signed [31:0] metric_eta_y;
	logic [31:0] cell_volume;
	logic boundary_cell;
	modport source(output valid, density, momentum_x, momentum_y, total_energy,
		metric_xi_x, metric_xi_y, metric_eta_x, metric_eta_y, cell_volume,
		boundary_cell, input ready);
	modport sink(input valid, density, momentum_x, momentum_y, total_energy,
		metric_xi_x, metric_xi_y, metric_eta_x, metric_eta_y, cell_volume,
		boundary_cell, output ready);
endinterface

### rtl/lcts_out_if.sv
// Result item channel of the local CFL time step block.
// No dependencies.
interface lcts_out_if;
	logic valid;
	logic ready;
	logic [31:0] radius_xi;
	logic [31:0] radius_eta;
	logic [31:0] time_step;
	logic [1:0] status;
	modport source(output valid, radius_xi, radius_eta, time_step, status, input ready);
	modport sink(input valid, radius_xi, radius_eta, time_step, status, output ready);
endinterface

### rtl/lcts_cfg_if.sv
// Register write channel of the local CFL time step block.
// No dependencies.
interface lcts_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [25:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/lcts_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies.
module lcts_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [NW-1:0] num_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar j = 0; j < NW; j++) begin : g_stg
		logic [NW-1:0] num_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic ge;
		if (j == 0) begin : g_first
			assign num_in = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign num_in = num_s[j-1];
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
		end
		assign trial = {rem_in, num_in[NW-1]};
		assign ge = trial >= {1'b0, den_in};
		assign diff = trial - {1'b0, den_in};
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[j] <= {num_in[NW-2:0], ge};
				rem_s[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[j] <= den_in;
			end
		end
	end

	assign quo = num_s[NW-1];
endmodule

### rtl/lcts_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// No dependencies.
module lcts_sqrt #(
	parameter int R = 24
) (
	input logic clk,
	input logic en,
	input logic [2*R-1:0] rad,
	output logic [R-1:0] root
);
	logic [2*R-1:0] rad_s [R];
	logic [R+1:0] rem_s [R];
	logic [R-1:0] root_s [R];

	for (genvar j = 0; j < R; j++) begin : g_stg
		logic [2*R-1:0] rad_in;
		logic [R+1:0] rem_in;
		logic [R-1:0] root_in;
		logic [R+3:0] cur;
		logic [R+3:0] trial;
		logic [R+3:0] diff;
		logic ge;
		if (j == 0) begin : g_first
			assign rad_in = rad;
			assign rem_in = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in = rad_s[j-1];
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
		end
		assign cur = {rem_in, rad_in[2*R-1:2*R-2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge = cur >= trial;
		assign diff = cur - trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j] <= {rad_in[2*R-3:0], 2'b00};
				rem_s[j] <= ge ? diff[R+1:0] : cur[R+1:0];
				root_s[j] <= {root_in[R-2:0], ge};
			end
		end
	end

	assign root = root_s[R-1];
endmodule

### rtl/lcts_delay.sv
// Enabled shift line that keeps side values in step with the pipeline.
// No dependencies.
module lcts_delay #(
	parameter int W = 32,
	parameter int D = 4
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] d_s [D];

	for (genvar j = 0; j < D; j++) begin : g_stg
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j] <= (j == 0) ? din : d_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign dout = d_s[D-1];
endmodule

### rtl/local_cfl_time_step.sv
// Local CFL time step: per cell spectral radii and time step, Q16.16, one item per cycle unless stalled.
// Depends on lcts_pkg, the three channel interfaces, lcts_div, lcts_sqrt, lcts_delay and
// the assertion macro header.
//
// The block takes one cell per clock while the output buffer is not full. Each result
// passes the bit-serial stages in series: the 48-step velocity and energy quotients, the
// 24-step sound speed root and the 59-step time step quotient. A two-entry output buffer
// lets the pipeline keep accepting while a finished result waits. Registers must be
// written through the cfg channel only while idle; the block itself does not enforce this.
`include "local_cfl_time_step_assert.svh"
module local_cfl_time_step (
	input logic clk,
	input logic arst_n,
	lcts_in_if.sink item_in,
	lcts_out_if.source item_out,
	lcts_cfg_if.sink cfg
);
	import lcts_pkg::*;

	localparam int DQ = 32 + FRAC;
	localparam int NR = 32;
	localparam int CR = 24;
	localparam int VR = 24;
	localparam int FQ = 26 + FRAC;
	localparam int TQ = 59;
	localparam int S_INNER = DQ + 3;
	localparam int S_GT = S_INNER + 4;
	localparam int S_AC = S_GT + CR + 1;
	localparam int S_ACS = S_AC + 1;
	localparam int S_RAD = S_ACS + 1;
	localparam int S_RMAX = S_RAD + 1;
	localparam int S_LAST = S_RMAX + TQ;
	localparam int NSTG = S_LAST + 1;
	localparam int S_NEND = NR + 1;
	localparam int S_DTP = VR + FQ + 1;

	logic [17:0] gamma_q;
	logic [25:0] cfl_q;
	logic [NSTG-1:0] vld_s;
	logic [1:0] cnt_q;
	res_t ent0_q, ent1_q, res;
	logic adv, push, pop;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			cfl_q <= CFL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GAMMA: gamma_q <= cfg.data[17:0];
				CFG_CFL: cfl_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pipeline control.
	assign adv = cnt_q != 2'd2;
	assign item_in.ready = adv;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], item_in.valid};
		end
	end

	// Entry: velocity and energy quotients, metric norms, volume root.
	logic [31:0] rho, mx_mag, my_mag, xa, xb, ea, eb;
	logic [63:0] xa2_s0, xb2_s0, ea2_s0, eb2_s0, nxi_s1, neta_s1;
	logic [DQ-1:0] uq, vq, eq;
	logic [129:0] side_d;
	logic [NR-1:0] nxi_r, neta_r, nxi_d, neta_d;

	always_comb begin
		rho = (item_in.density == '0) ? 32'd1 : item_in.density;
		mx_mag = item_in.momentum_x[31] ? (~item_in.momentum_x + 32'd1) : item_in.momentum_x;
		my_mag = item_in.momentum_y[31] ? (~item_in.momentum_y + 32'd1) : item_in.momentum_y;
		xa = item_in.metric_xi_x[31] ? (~item_in.metric_xi_x + 32'd1) : item_in.metric_xi_x;
		xb = item_in.metric_xi_y[31] ? (~item_in.metric_xi_y + 32'd1) : item_in.metric_xi_y;
		ea = item_in.metric_eta_x[31] ? (~item_in.metric_eta_x + 32'd1) : item_in.metric_eta_x;
		eb = item_in.metric_eta_y[31] ? (~item_in.metric_eta_y + 32'd1) : item_in.metric_eta_y;
	end

	lcts_div #(.NW(DQ), .DW(32)) u_div_u (.clk, .en(adv),
		.num({mx_mag, {FRAC{1'b0}}}), .den(rho), .quo(uq));
	lcts_div #(.NW(DQ), .DW(32)) u_div_v (.clk, .en(adv),
		.num({my_mag, {FRAC{1'b0}}}), .den(rho), .quo(vq));
	lcts_div #(.NW(DQ), .DW(32)) u_div_e (.clk, .en(adv),
		.num({item_in.total_energy, {FRAC{1'b0}}}), .den(rho), .quo(eq));
	lcts_delay #(.W(130), .D(DQ)) u_dly_side (.clk, .en(adv),
		.din({item_in.metric_xi_x, item_in.metric_xi_y, item_in.metric_eta_x,
			item_in.metric_eta_y, item_in.momentum_x[31], item_in.momentum_y[31]}),
		.dout(side_d));

	always_ff @(posedge clk) begin
		if (adv) begin
			xa2_s0 <= 64'(xa) * 64'(xa);
			xb2_s0 <= 64'(xb) * 64'(xb);
			ea2_s0 <= 64'(ea) * 64'(ea);
			eb2_s0 <= 64'(eb) * 64'(eb);
			nxi_s1 <= xa2_s0 + xb2_s0;
			neta_s1 <= ea2_s0 + eb2_s0;
		end
	end

	lcts_sqrt #(.R(NR)) u_sqrt_nxi (.clk, .en(adv), .rad(nxi_s1), .root(nxi_r));
	lcts_sqrt #(.R(NR)) u_sqrt_neta (.clk, .en(adv), .rad(neta_s1), .root(neta_r));
	lcts_delay #(.W(2*NR), .D(S_AC-1-S_NEND)) u_dly_norm (.clk, .en(adv),
		.din({nxi_r, neta_r}), .dout({nxi_d, neta_d}));

	// Volume path: effective CFL times volume.
	logic [VR-1:0] vroot;
	logic [24:0] den_s24;
	logic [FQ-1:0] fq;
	logic [31:0] vol_d;
	logic [26:0] ceff;
	logic [58:0] dtp_s67, dtp_d;

	lcts_sqrt #(.R(VR)) u_sqrt_vol (.clk, .en(adv),
		.rad({item_in.cell_volume, {FRAC{1'b0}}}), .root(vroot));
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s24 <= 25'(ONE18) + 25'(vroot);
		end
	end
	lcts_div #(.NW(FQ), .DW(25)) u_div_cfl (.clk, .en(adv),
		.num({cfl_q, {FRAC{1'b0}}}), .den(den_s24), .quo(fq));
	lcts_delay #(.W(32), .D(S_DTP)) u_dly_vol (.clk, .en(adv),
		.din(item_in.cell_volume), .dout(vol_d));
	assign ceff = (fq < FQ'(ONE18)) ? 27'(ONE18) : fq[26:0];
	always_ff @(posedge clk) begin
		if (adv) begin
			dtp_s67 <= 59'(ceff) * 59'(vol_d);
		end
	end
	lcts_delay #(.W(59), .D(S_RMAX-S_DTP)) u_dly_dtp (.clk, .en(adv),
		.din(dtp_s67), .dout(dtp_d));

	// Velocities, kinetic energy, temperature and convective terms.
	logic [30:0] usat, vsat, umag_s48, vmag_s48;
	logic [31:0] upos, vpos;
	logic signed [31:0] u_s48, v_s48, xa_s48, xb_s48, ea_s48, eb_s48;
	logic [DQ-1:0] e_s48, e_s49, e_s50;
	logic [61:0] uu_s49, vv_s49;
	logic signed [63:0] p1_s49, p2_s49, p3_s49, p4_s49;
	logic [62:0] kesum;
	logic [45:0] ke_s50;
	logic signed [64:0] sxi_s50, seta_s50;
	logic [64:0] mxi, meta;
	logic neg_s51;
	logic [DQ-1:0] inner_s51;
	logic [31:0] cxi_s51, ceta_s51;
	logic [17:0] g1;
	logic [65:0] tprod_s52;
	logic [31:0] temp_s53, gt_s55;
	logic [49:0] gprod_s54;

	always_comb begin
		usat = (uq[DQ-1:31] != '0) ? 31'h7FFF_FFFF : uq[30:0];
		vsat = (vq[DQ-1:31] != '0) ? 31'h7FFF_FFFF : vq[30:0];
		upos = {1'b0, usat};
		vpos = {1'b0, vsat};
		kesum = 63'(uu_s49) + 63'(vv_s49);
		mxi = sxi_s50[64] ? (~sxi_s50 + 65'd1) : sxi_s50;
		meta = seta_s50[64] ? (~seta_s50 + 65'd1) : seta_s50;
		g1 = (gamma_q > ONE18) ? (gamma_q - ONE18) : 18'd0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			umag_s48 <= usat;
			vmag_s48 <= vsat;
			u_s48 <= side_d[1] ? (~upos + 32'd1) : upos;
			v_s48 <= side_d[0] ? (~vpos + 32'd1) : vpos;
			{xa_s48, xb_s48, ea_s48, eb_s48} <= side_d[129:2];
			e_s48 <= eq;

			uu_s49 <= 62'(umag_s48) * 62'(umag_s48);
			vv_s49 <= 62'(vmag_s48) * 62'(vmag_s48);
			p1_s49 <= xa_s48 * u_s48;
			p2_s49 <= xb_s48 * v_s48;
			p3_s49 <= ea_s48 * u_s48;
			p4_s49 <= eb_s48 * v_s48;
			e_s49 <= e_s48;

			ke_s50 <= kesum[62:FRAC+1];
			sxi_s50 <= $signed({p1_s49[63], p1_s49}) + $signed({p2_s49[63], p2_s49});
			seta_s50 <= $signed({p3_s49[63], p3_s49}) + $signed({p4_s49[63], p4_s49});
			e_s50 <= e_s49;

			neg_s51 <= e_s50 < DQ'(ke_s50);
			inner_s51 <= (e_s50 < DQ'(ke_s50)) ? '0 : e_s50 - DQ'(ke_s50);
			cxi_s51 <= (mxi[63:48] != '0) ? MAX32 : mxi[47:16];
			ceta_s51 <= (meta[63:48] != '0) ? MAX32 : meta[47:16];

			tprod_s52 <= 66'(inner_s51) * 66'(g1);
			temp_s53 <= (tprod_s52[65:48] != '0) ? MAX32 : tprod_s52[47:16];
			gprod_s54 <= 50'(gamma_q) * 50'(temp_s53);
			gt_s55 <= (gprod_s54[49:48] != '0) ? MAX32 : gprod_s54[47:16];
		end
	end

	// Acoustic terms, radii and their maximum.
	logic [CR-1:0] c_r;
	logic [31:0] cxi_d, ceta_d;
	logic [55:0] axi_s80, aeta_s80;
	logic [31:0] axi_s81, aeta_s81;
	logic [32:0] rsum_xi, rsum_eta;
	logic [31:0] rxi_s82, reta_s82, rmax_s83;
	logic zr_s83;

	lcts_sqrt #(.R(CR)) u_sqrt_c (.clk, .en(adv),
		.rad({gt_s55, {FRAC{1'b0}}}), .root(c_r));
	lcts_delay #(.W(64), .D(S_ACS-S_INNER)) u_dly_conv (.clk, .en(adv),
		.din({cxi_s51, ceta_s51}), .dout({cxi_d, ceta_d}));

	assign rsum_xi = {1'b0, cxi_d} + {1'b0, axi_s81};
	assign rsum_eta = {1'b0, ceta_d} + {1'b0, aeta_s81};

	always_ff @(posedge clk) begin
		if (adv) begin
			axi_s80 <= 56'(nxi_d) * 56'(c_r);
			aeta_s80 <= 56'(neta_d) * 56'(c_r);
			axi_s81 <= (axi_s80[55:48] != '0) ? MAX32 : axi_s80[47:16];
			aeta_s81 <= (aeta_s80[55:48] != '0) ? MAX32 : aeta_s80[47:16];
			rxi_s82 <= rsum_xi[32] ? MAX32 : rsum_xi[31:0];
			reta_s82 <= rsum_eta[32] ? MAX32 : rsum_eta[31:0];
			rmax_s83 <= (rxi_s82 > reta_s82) ? rxi_s82 : reta_s82;
			zr_s83 <= (rxi_s82 == '0) && (reta_s82 == '0);
		end
	end

	// Time step quotient and result assembly.
	logic [TQ-1:0] dq;
	logic [31:0] rxi_d, reta_d;
	logic zr_d, neg_d, bnd_d;

	lcts_div #(.NW(TQ), .DW(32)) u_div_dt (.clk, .en(adv),
		.num(dtp_d), .den(rmax_s83), .quo(dq));
	lcts_delay #(.W(64), .D(S_LAST-S_RAD)) u_dly_rad (.clk, .en(adv),
		.din({rxi_s82, reta_s82}), .dout({rxi_d, reta_d}));
	lcts_delay #(.W(1), .D(S_LAST-S_RMAX)) u_dly_zr (.clk, .en(adv),
		.din(zr_s83), .dout(zr_d));
	lcts_delay #(.W(1), .D(S_LAST-S_INNER)) u_dly_neg (.clk, .en(adv),
		.din(neg_s51), .dout(neg_d));
	lcts_delay #(.W(1), .D(NSTG)) u_dly_bnd (.clk, .en(adv),
		.din(item_in.boundary_cell), .dout(bnd_d));

	always_comb begin
		res = '0;
		if (!bnd_d) begin
			res.radius_xi = rxi_d;
			res.radius_eta = reta_d;
			if (zr_d) begin
				res.time_step = MAX32;
				res.status = ST_ZERO_RADII;
			end else begin
				res.time_step = (dq[TQ-1:32] != '0) ? MAX32 : dq[31:0];
				res.status = neg_d ? ST_NEG_TEMP : ST_OK;
			end
		end
	end

	// Two-entry output buffer.
	assign push = adv && vld_s[NSTG-1];
	assign pop = item_out.valid && item_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= res;
				end else begin
					ent1_q <= res;
				end
			end
			2'b01: ent0_q <= ent1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= res;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign item_out.valid = cnt_q != 2'd0;
	assign item_out.radius_xi = ent0_q.radius_xi;
	assign item_out.radius_eta = ent0_q.radius_eta;
	assign item_out.time_step = ent0_q.time_step;
	assign item_out.status = ent0_q.status;

	`LCTS_ASSERT_NEXT(a_in_enters, item_in.valid && item_in.ready, vld_s[0])
	`LCTS_ASSERT_SAME(a_zero_radii_step, item_out.valid && item_out.status == ST_ZERO_RADII,
		item_out.time_step == MAX32)
	`LCTS_ASSERT_SAME(a_zero_radii_vals, item_out.valid && item_out.status == ST_ZERO_RADII,
		item_out.radius_xi == '0 && item_out.radius_eta == '0)
endmodule
